>>> hw/rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared constants and types for the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int NUM_TIMERS = 32;
   localparam int NUM_QUEUES = 16;
   localparam int IDX_W      = 5;
   localparam int DEST_W     = 4;
   localparam int WORD_W     = 32;
   localparam int CFG_W      = 6;

   localparam logic [2:0] REQ_ALLOC = 3'd0;
   localparam logic [2:0] REQ_FREE  = 3'd1;
   localparam logic [2:0] REQ_SET   = 3'd2;
   localparam logic [2:0] REQ_ARM   = 3'd3;
   localparam logic [2:0] REQ_TICK  = 3'd4;

   localparam logic [2:0] EV_ALLOCATED = 3'd0;
   localparam logic [2:0] EV_NO_FREE   = 3'd1;
   localparam logic [2:0] EV_DONE      = 3'd2;
   localparam logic [2:0] EV_EXPIRED   = 3'd3;
   localparam logic [2:0] EV_TASK      = 3'd4;

   localparam logic [1:0] ST_FREE  = 2'd0;
   localparam logic [1:0] ST_ALLOC = 2'd1;
   localparam logic [1:0] ST_ARMED = 2'd2;

   localparam logic [WORD_W-1:0] ALL_ONES = 32'hffff_ffff;

   typedef struct packed {
      logic              status_we;
      logic [IDX_W-1:0]  status_wa;
      logic [1:0]        status_wd;
      logic              dl_we;
      logic [IDX_W-1:0]  dl_wa;
      logic [WORD_W-1:0] dl_wd;
      logic              link0_we;
      logic [IDX_W-1:0]  link0_wa;
      logic [IDX_W-1:0]  link0_wd;
      logic              link1_we;
      logic [IDX_W-1:0]  link1_wa;
      logic [IDX_W-1:0]  link1_wd;
      logic              set_we;
      logic [IDX_W-1:0]  set_wa;
      logic [DEST_W-1:0] set_dest;
      logic [WORD_W-1:0] set_payload;
   } stq_wr_type;

   typedef struct packed {
      logic [IDX_W-1:0] status_ra;
      logic [IDX_W-1:0] dl_ra;
      logic [IDX_W-1:0] entry_ra;
   } stq_rd_type;

endpackage

>>> hw/rtl/stq_entry_store.sv
// ----------------------------------------------------------------------------
// stq_entry_store
// Per-entry status, deadline, link, destination and payload storage.
// ----------------------------------------------------------------------------
module stq_entry_store (
   input  logic                              clock,
   input  logic                              reset,
   input  stq_pkg::stq_wr_type               wr,
   input  stq_pkg::stq_rd_type               rd,
   output logic [1:0]                        status_rd,
   output logic [stq_pkg::WORD_W-1:0]        dl_rd,
   output logic [stq_pkg::IDX_W-1:0]         link_rd,
   output logic [stq_pkg::DEST_W-1:0]        dest_rd,
   output logic [stq_pkg::WORD_W-1:0]        payload_rd
);

   logic [1:0]                 status_ff  [stq_pkg::NUM_TIMERS];
   logic [stq_pkg::WORD_W-1:0] deadline_ff[stq_pkg::NUM_TIMERS];
   logic [stq_pkg::IDX_W-1:0]  link_ff    [stq_pkg::NUM_TIMERS];
   logic [stq_pkg::DEST_W-1:0] dest_ff    [stq_pkg::NUM_TIMERS];
   logic [stq_pkg::WORD_W-1:0] payload_ff [stq_pkg::NUM_TIMERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < stq_pkg::NUM_TIMERS; i++) begin
            status_ff[i]   <= stq_pkg::ST_FREE;
            deadline_ff[i] <= '0;
         end
         status_ff[0]   <= stq_pkg::ST_ARMED;
         deadline_ff[0] <= stq_pkg::ALL_ONES;
      end else begin
         if (wr.status_we) status_ff[wr.status_wa] <= wr.status_wd;
         if (wr.dl_we) deadline_ff[wr.dl_wa] <= wr.dl_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.link0_we) link_ff[wr.link0_wa] <= wr.link0_wd;
      if (wr.link1_we) link_ff[wr.link1_wa] <= wr.link1_wd;
      if (wr.set_we) begin
         dest_ff[wr.set_wa]    <= wr.set_dest;
         payload_ff[wr.set_wa] <= wr.set_payload;
      end
   end

   assign status_rd  = status_ff[rd.status_ra];
   assign dl_rd      = deadline_ff[rd.dl_ra];
   assign link_rd    = link_ff[rd.entry_ra];
   assign dest_rd    = dest_ff[rd.entry_ra];
   assign payload_rd = payload_ff[rd.entry_ra];

endmodule

>>> hw/rtl/sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Pool of one-shot timers kept as a deadline-sorted linked list.
// ----------------------------------------------------------------------------
// Requests enter on the req_ channel (valid/stall) and each gives one or more
// items on the rsp_ channel; rsp_last marks the final item of a request.
// One request is in work at a time; req_stall is high until its last item
// sits in the output register. A single sequencer drives one compare unit
// over the entry store, one entry per cycle unless rsp_stall holds an item back:
//   free, set, unknown: a single DONE item
//   allocate: scan up from entry 0 to the lowest free entry
//   arm: write deadline and status, insert at the head or walk the list
//   tick: a DONE item when nothing is due, else expire due entries from the
//   head, then the trailing items.
// The output register takes a new item while the previous one is taken, so
// rsp_stall only stretches the work while it is held high.
// Reset (synchronous) frees all entries, arms the entry 0 sentinel at the
// all-ones deadline, clears the tick count and sets task_timer_index to 32.
// csr_ is an APB-style port holding task_timer_index at address 0.
// ----------------------------------------------------------------------------
module sorted_timer_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [4:0]  req_timer_index,
   input  logic [3:0]  req_dest_queue,
   input  logic [31:0] req_payload,
   input  logic [31:0] req_delay,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [4:0]  rsp_timer_index_res,
   output logic [3:0]  rsp_dest_queue_res,
   output logic [31:0] rsp_payload_res,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DONE      = 4'd1;
   localparam logic [3:0] S_ALLOC     = 4'd2;
   localparam logic [3:0] S_ARM_START = 4'd3;
   localparam logic [3:0] S_ARM_HEAD  = 4'd4;
   localparam logic [3:0] S_ARM_WALK  = 4'd5;
   localparam logic [3:0] S_TICK_CHK  = 4'd6;
   localparam logic [3:0] S_TICK_WALK = 4'd7;
   localparam logic [3:0] S_TICK_END  = 4'd8;

   localparam int IW = stq_pkg::IDX_W;
   localparam int WW = stq_pkg::WORD_W;

   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] t_ff, t_in;
   logic [IW-1:0] n_ff, n_in;
   logic [IW-1:0] head_ff, head_in;
   logic [WW-1:0] dl_ff, dl_in;
   logic [WW-1:0] earliest_ff, earliest_in;
   logic [WW-1:0] tick_ff, tick_in;
   logic [stq_pkg::NUM_TIMERS-1:0] visited_ff, visited_in;
   logic          ts_ff, ts_in;
   logic          pend_v_ff, pend_v_in;
   logic [IW-1:0] pend_idx_ff, pend_idx_in;
   logic [3:0]    pend_dq_ff, pend_dq_in;
   logic [WW-1:0] pend_pl_ff, pend_pl_in;
   logic [stq_pkg::CFG_W-1:0] task_ff, task_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_ev_ff, rsp_ev_in;
   logic [IW-1:0] rsp_idx_ff, rsp_idx_in;
   logic [3:0]    rsp_dq_ff, rsp_dq_in;
   logic [WW-1:0] rsp_pl_ff, rsp_pl_in;
   logic          rsp_last_ff, rsp_last_in;

   stq_pkg::stq_wr_type wr;
   stq_pkg::stq_rd_type rd;
   logic [1:0]    status_rd;
   logic [WW-1:0] dl_rd;
   logic [IW-1:0] link_rd;
   logic [3:0]    dest_rd;
   logic [WW-1:0] payload_rd;

   logic [WW-1:0] cmp_a, cmp_b;
   logic          cmp_le;
   logic          out_free, emit, due;
   logic [2:0]    e_ev;
   logic [IW-1:0] e_idx;
   logic [3:0]    e_dq;
   logic [WW-1:0] e_pl;
   logic          e_last;
   logic          cfg_wr;

   stq_entry_store u_store (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .rd         (rd),
      .status_rd  (status_rd),
      .dl_rd      (dl_rd),
      .link_rd    (link_rd),
      .dest_rd    (dest_rd),
      .payload_rd (payload_rd)
   );

   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 3'd0) ? {26'd0, task_ff} : 32'd0;
   assign task_in    = (cfg_wr && csr_paddr == 3'd0) ? csr_pwdata[5:0] : task_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rd.status_ra = n_ff;
      rd.entry_ra  = t_ff;
      if (state_ff == S_ARM_HEAD)      rd.dl_ra = head_ff;
      else if (state_ff == S_ARM_WALK) rd.dl_ra = link_rd;
      else                             rd.dl_ra = t_ff;
      if (state_ff == S_TICK_CHK) begin
         cmp_a = earliest_ff;
         cmp_b = tick_ff;
      end else if (state_ff == S_TICK_WALK) begin
         cmp_a = dl_rd;
         cmp_b = tick_ff;
      end else begin
         cmp_a = dl_ff;
         cmp_b = dl_rd;
      end
   end

   assign cmp_le = (cmp_a <= cmp_b);
   assign due    = !visited_ff[t_ff] && cmp_le;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      t_in        = t_ff;
      n_in        = n_ff;
      head_in     = head_ff;
      dl_in       = dl_ff;
      earliest_in = earliest_ff;
      tick_in     = tick_ff;
      visited_in  = visited_ff;
      ts_in       = ts_ff;
      pend_v_in   = pend_v_ff;
      pend_idx_in = pend_idx_ff;
      pend_dq_in  = pend_dq_ff;
      pend_pl_in  = pend_pl_ff;
      wr          = '0;
      emit        = 1'b0;
      e_ev        = stq_pkg::EV_DONE;
      e_idx       = '0;
      e_dq        = '0;
      e_pl        = '0;
      e_last      = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               idx_in = req_timer_index;
               n_in   = '0;
               case (req_type)
                  stq_pkg::REQ_ALLOC: state_in = S_ALLOC;
                  stq_pkg::REQ_FREE: begin
                     wr.status_we = 1'b1;
                     wr.status_wa = req_timer_index;
                     wr.status_wd = stq_pkg::ST_FREE;
                     state_in     = S_DONE;
                  end
                  stq_pkg::REQ_SET: begin
                     wr.set_we      = 1'b1;
                     wr.set_wa      = req_timer_index;
                     wr.set_dest    = req_dest_queue;
                     wr.set_payload = req_payload;
                     state_in       = S_DONE;
                  end
                  stq_pkg::REQ_ARM: begin
                     dl_in    = req_delay + tick_ff;
                     state_in = S_ARM_START;
                  end
                  stq_pkg::REQ_TICK: begin
                     tick_in  = tick_ff + 32'd1;
                     state_in = S_TICK_CHK;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_DONE: begin
            emit = 1'b1;
            if (out_free) state_in = S_IDLE;
         end
         S_ALLOC: begin
            if (status_rd == stq_pkg::ST_FREE) begin
               emit  = 1'b1;
               e_ev  = stq_pkg::EV_ALLOCATED;
               e_idx = n_ff;
               if (out_free) begin
                  wr.status_we = 1'b1;
                  wr.status_wa = n_ff;
                  wr.status_wd = stq_pkg::ST_ALLOC;
                  state_in     = S_IDLE;
               end
            end else if (n_ff == IW'(stq_pkg::NUM_TIMERS - 1)) begin
               emit = 1'b1;
               e_ev = stq_pkg::EV_NO_FREE;
               if (out_free) state_in = S_IDLE;
            end else begin
               n_in = n_ff + 1'b1;
            end
         end
         S_ARM_START: begin
            wr.dl_we     = 1'b1;
            wr.dl_wa     = idx_ff;
            wr.dl_wd     = dl_ff;
            wr.status_we = 1'b1;
            wr.status_wa = idx_ff;
            wr.status_wd = stq_pkg::ST_ARMED;
            state_in     = S_ARM_HEAD;
         end
         S_ARM_HEAD: begin
            if (cmp_le) begin
               wr.link1_we = 1'b1;
               wr.link1_wa = idx_ff;
               wr.link1_wd = head_ff;
               head_in     = idx_ff;
               earliest_in = dl_ff;
               state_in    = S_DONE;
            end else begin
               t_in     = head_ff;
               n_in     = '0;
               state_in = S_ARM_WALK;
            end
         end
         S_ARM_WALK: begin
            if (cmp_le || n_ff == IW'(stq_pkg::NUM_TIMERS - 1)) begin
               wr.link0_we = 1'b1;
               wr.link0_wa = t_ff;
               wr.link0_wd = idx_ff;
               wr.link1_we = 1'b1;
               wr.link1_wa = idx_ff;
               wr.link1_wd = link_rd;
               state_in    = S_DONE;
            end else begin
               t_in = link_rd;
               n_in = n_ff + 1'b1;
            end
         end
         S_TICK_CHK: begin
            if (!cmp_le) begin
               state_in = S_DONE;
            end else begin
               t_in       = head_ff;
               visited_in = '0;
               ts_in      = 1'b0;
               pend_v_in  = 1'b0;
               state_in   = S_TICK_WALK;
            end
         end
         S_TICK_WALK: begin
            if (!due) begin
               head_in     = t_ff;
               earliest_in = dl_rd;
               state_in    = S_TICK_END;
            end else if (task_ff == {1'b0, t_ff}) begin
               visited_in[t_ff] = 1'b1;
               wr.status_we     = 1'b1;
               wr.status_wa     = t_ff;
               wr.status_wd     = stq_pkg::ST_ALLOC;
               ts_in            = 1'b1;
               t_in             = link_rd;
            end else if (!pend_v_ff || out_free) begin
               emit             = pend_v_ff;
               e_ev             = stq_pkg::EV_EXPIRED;
               e_idx            = pend_idx_ff;
               e_dq             = pend_dq_ff;
               e_pl             = pend_pl_ff;
               e_last           = 1'b0;
               pend_v_in        = 1'b1;
               pend_idx_in      = t_ff;
               pend_dq_in       = dest_rd;
               pend_pl_in       = payload_rd;
               visited_in[t_ff] = 1'b1;
               wr.status_we     = 1'b1;
               wr.status_wa     = t_ff;
               wr.status_wd     = stq_pkg::ST_ALLOC;
               t_in             = link_rd;
            end
         end
         S_TICK_END: begin
            emit = 1'b1;
            if (pend_v_ff) begin
               e_ev   = stq_pkg::EV_EXPIRED;
               e_idx  = pend_idx_ff;
               e_dq   = pend_dq_ff;
               e_pl   = pend_pl_ff;
               e_last = !ts_ff;
               if (out_free) begin
                  pend_v_in = 1'b0;
                  if (!ts_ff) state_in = S_IDLE;
               end
            end else begin
               if (ts_ff) begin
                  e_ev  = stq_pkg::EV_TASK;
                  e_idx = task_ff[IW-1:0];
               end
               if (out_free) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_dq_in    = rsp_dq_ff;
      rsp_pl_in    = rsp_pl_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_ev_in    = e_ev;
         rsp_idx_in   = e_idx;
         rsp_dq_in    = e_dq;
         rsp_pl_in    = e_pl;
         rsp_last_in  = e_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         earliest_ff  <= stq_pkg::ALL_ONES;
         tick_ff      <= '0;
         task_ff      <= 6'd32;
         rsp_valid_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
         ts_ff        <= 1'b0;
         visited_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         earliest_ff  <= earliest_in;
         tick_ff      <= tick_in;
         task_ff      <= task_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_v_ff    <= pend_v_in;
         ts_ff        <= ts_in;
         visited_ff   <= visited_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      t_ff        <= t_in;
      n_ff        <= n_in;
      dl_ff       <= dl_in;
      pend_idx_ff <= pend_idx_in;
      pend_dq_ff  <= pend_dq_in;
      pend_pl_ff  <= pend_pl_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_dq_ff   <= rsp_dq_in;
      rsp_pl_ff   <= rsp_pl_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = rsp_ev_ff;
   assign rsp_timer_index_res = rsp_idx_ff;
   assign rsp_dest_queue_res  = rsp_dq_ff;
   assign rsp_payload_res     = rsp_pl_ff;
   assign rsp_last            = rsp_last_ff;

endmodule
